// File: rtl/cwd_pkg.sv
// Package for the curve warp distance block: payload types, codes and sequencer states.
package cwd_pkg;

  // Low bits of each coordinate field that take part in the distance
  localparam int COORD_BITS = 16;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;
  localparam logic [1:0] STATUS_SATURATED = 2'd3;

  localparam logic METRIC_FRECHET = 1'b0;
  localparam logic METRIC_DTW     = 1'b1;

  localparam logic CURVE_FIRST  = 1'b0;
  localparam logic CURVE_SECOND = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [15:0] coord_z;
    logic        last_point;
  } in_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [1:0]  status;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ADD,
    S_SQRT,
    S_CELL,
    S_DONE
  } state_t;

endpackage

// File: rtl/cwd_isqrt.sv
// Iterative floor square root, one result bit per cycle.
module cwd_isqrt #(
  parameter int SQ_W = 36
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SQ_W-1:0]     value,
  output logic                busy,
  output logic [SQ_W/2-1:0]   root
);

  localparam int RT_W  = SQ_W / 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [SQ_W-1:0]  src;
  logic [RT_W+1:0]  rem;
  logic [CNT_W-1:0] steps;
  logic [RT_W+1:0]  rem_sh;
  logic [RT_W+1:0]  trial;

  always_comb begin
    rem_sh = {rem[RT_W-1:0], src[SQ_W-1 -: 2]};
    trial  = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= CNT_W'(RT_W);
      src   <= value;
      rem   <= '0;
      root  <= '0;
    end else if (busy) begin
      src <= {src[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RT_W-2:0], 1'b0};
      end
      steps <= steps - CNT_W'(1);
      if (steps == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/curve_warp_distance_dp_top.sv
// Top level of the curve warp distance block: point stores, grid sequencer, result register.
//
// Usage: points arrive on in_valid/in_ready, one per item; req_type picks the
// first or second curve. Loading items are taken one per cycle. The second
// curve's item marked last_point closes the job: the block drops in_ready and
// walks the N by M grid one cell at a time, then presents one result on
// out_valid/out_ready with distance and status.
// Each cell runs in order: a registered read of both point stores and the row buffer,
// one multiply and one add per dimension, the shared bit-serial square root plus a
// hand-off of its root, and the cell update. Empty or overflowed jobs skip the grid
// walk and go straight to loading the result register.
// The result waits in an output register; loading items are still accepted
// while it waits, but the next job's result holds until it is taken.
// metric_mode is written through cfg_we/cfg_data; the user must do so only while the block
// is idle, as the block itself does not enforce it. Reset (rst, synchronous) clears counts,
// overflow flag, metric_mode and all handshake state; point stores and the row buffer need no clearing.
module curve_warp_distance_dp_top #(
  parameter int MAX_POINTS = 64,
  parameter int DIMENSIONS = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cwd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cwd_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_data
);

  localparam int COORD_BITS = cwd_pkg::COORD_BITS;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DIF_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * COORD_BITS + 4;
  localparam int RT_W  = SQ_W / 2;
  localparam int DIM_W = 2;

  typedef logic [2:0][COORD_BITS-1:0] pnt_t;

  typedef struct packed {
    logic rd_en;
    logic mul_en;
    logic add_en;
    logic sqrt_start;
    logic cell_en;
    logic load_out;
  } ctl_t;

  cwd_pkg::state_t state, state_next;
  ctl_t            ctl;

  pnt_t        mem_a [MAX_POINTS];
  pnt_t        mem_b [MAX_POINTS];
  logic [31:0] row   [MAX_POINTS];

  logic [CNT_W-1:0] cnt_a, cnt_b;
  logic             overflow;
  logic             metric_mode;
  logic [IDX_W-1:0] ii, jj;
  logic [DIM_W-1:0] dd;
  pnt_t             rd_a, rd_b;
  logic [31:0]      up, left, diag;
  logic [SQ_W-1:0]  acc, prod;
  logic [1:0]       res_status;
  logic [31:0]      res_dist;

  logic             accept, cur_full, closing;
  logic             ov_n;
  logic [CNT_W-1:0] cnt_b_n;
  logic             sqrt_busy;
  logic [RT_W-1:0]  sqrt_root;
  logic [SQ_W-1:0]  sqrt_val;
  logic             last_dim, last_col, last_row;
  logic signed [DIF_W-1:0]   diff;
  logic signed [2*DIF_W-1:0] sq;
  logic [31:0]      loc, best, cell_cost;
  logic [32:0]      sum;
  pnt_t             pnt_in;

  assign in_ready = (state == cwd_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cur_full = (in_data.req_type == cwd_pkg::CURVE_FIRST) ?
                    (cnt_a == CNT_W'(MAX_POINTS)) : (cnt_b == CNT_W'(MAX_POINTS));
  assign closing  = accept && (in_data.req_type == cwd_pkg::CURVE_SECOND) &&
                    in_data.last_point;
  assign ov_n     = overflow || cur_full;
  assign cnt_b_n  = cnt_b + CNT_W'(!cur_full);
  assign pnt_in   = {in_data.coord_z[COORD_BITS-1:0], in_data.coord_y[COORD_BITS-1:0],
                     in_data.coord_x[COORD_BITS-1:0]};

  assign last_dim = (dd == DIM_W'(DIMENSIONS - 1));
  assign last_col = (CNT_W'(jj) == CNT_W'(cnt_b - CNT_W'(1)));
  assign last_row = (CNT_W'(ii) == CNT_W'(cnt_a - CNT_W'(1)));

  always_comb begin
    diff = DIF_W'($signed(rd_a[dd])) - DIF_W'($signed(rd_b[dd]));
    sq   = diff * diff;
  end

  assign sqrt_val = acc + prod;

  cwd_isqrt #(.SQ_W(SQ_W)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.sqrt_start),
    .value (sqrt_val),
    .busy  (sqrt_busy),
    .root  (sqrt_root)
  );

  // Neighbor min and combine for the current cell.
  always_comb begin
    loc = 32'(sqrt_root);
    if (ii == '0) begin
      best = left;
    end else if (jj == '0) begin
      best = up;
    end else begin
      best = (up < diag) ? up : diag;
      best = (left < best) ? left : best;
    end
    sum = {1'b0, best} + {1'b0, loc};
    if (ii == '0 && jj == '0) begin
      cell_cost = loc;
    end else if (metric_mode == cwd_pkg::METRIC_FRECHET) begin
      cell_cost = (best > loc) ? best : loc;
    end else begin
      cell_cost = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cwd_pkg::S_IDLE: begin
        if (closing) begin
          state_next = (ov_n || cnt_a == '0) ? cwd_pkg::S_DONE : cwd_pkg::S_RD;
        end
      end
      cwd_pkg::S_RD:   state_next = cwd_pkg::S_MUL;
      cwd_pkg::S_MUL:  state_next = cwd_pkg::S_ADD;
      cwd_pkg::S_ADD:  state_next = last_dim ? cwd_pkg::S_SQRT : cwd_pkg::S_MUL;
      cwd_pkg::S_SQRT: state_next = sqrt_busy ? cwd_pkg::S_SQRT : cwd_pkg::S_CELL;
      cwd_pkg::S_CELL: state_next = (last_col && last_row) ? cwd_pkg::S_DONE : cwd_pkg::S_RD;
      cwd_pkg::S_DONE: state_next = (!out_valid || out_ready) ? cwd_pkg::S_IDLE : cwd_pkg::S_DONE;
      default:         state_next = cwd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      cwd_pkg::S_RD:   ctl.rd_en = 1'b1;
      cwd_pkg::S_MUL:  ctl.mul_en = 1'b1;
      cwd_pkg::S_ADD: begin
        ctl.add_en     = 1'b1;
        ctl.sqrt_start = last_dim;
      end
      cwd_pkg::S_CELL: ctl.cell_en = 1'b1;
      cwd_pkg::S_DONE: ctl.load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cwd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= cwd_pkg::METRIC_FRECHET;
    end else if (cfg_we) begin
      metric_mode <= cfg_data;
    end
  end

  // Point stores and counts.
  always_ff @(posedge clk) begin
    if (accept && !cur_full) begin
      if (in_data.req_type == cwd_pkg::CURVE_FIRST) begin
        mem_a[cnt_a[IDX_W-1:0]] <= pnt_in;
      end else begin
        mem_b[cnt_b[IDX_W-1:0]] <= pnt_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a    <= '0;
      cnt_b    <= '0;
      overflow <= 1'b0;
    end else if (ctl.load_out) begin
      cnt_a    <= '0;
      cnt_b    <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      if (cur_full) begin
        overflow <= 1'b1;
      end else if (in_data.req_type == cwd_pkg::CURVE_FIRST) begin
        cnt_a <= cnt_a + CNT_W'(1);
      end else begin
        cnt_b <= cnt_b_n;
      end
    end
  end

  // Grid walk datapath.
  always_ff @(posedge clk) begin
    if (closing) begin
      ii         <= '0;
      jj         <= '0;
      res_dist   <= '0;
      res_status <= ov_n ? cwd_pkg::STATUS_OVERFLOW :
                    (cnt_a == '0) ? cwd_pkg::STATUS_EMPTY : cwd_pkg::STATUS_OK;
    end
    if (ctl.rd_en) begin
      rd_a <= mem_a[ii];
      rd_b <= mem_b[jj];
      up   <= row[jj];
      dd   <= '0;
      acc  <= '0;
    end
    if (ctl.mul_en) begin
      prod <= SQ_W'($unsigned(sq));
    end
    if (ctl.add_en) begin
      acc <= sqrt_val;
      dd  <= dd + DIM_W'(1);
    end
    if (ctl.cell_en) begin
      row[jj] <= cell_cost;
      left    <= cell_cost;
      diag    <= up;
      if (last_col) begin
        jj <= '0;
        ii <= ii + IDX_W'(1);
        if (last_row) begin
          res_dist   <= cell_cost;
          res_status <= (metric_mode == cwd_pkg::METRIC_DTW && cell_cost == 32'hFFFF_FFFF) ?
                        cwd_pkg::STATUS_SATURATED : cwd_pkg::STATUS_OK;
        end
      end else begin
        jj <= jj + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_data.distance <= res_dist;
      out_data.status   <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_sqrt_idle_at_cell: assert property (@(posedge clk) disable iff (rst)
    (state == cwd_pkg::S_CELL) |-> !sqrt_busy)
    else $error("square root still busy at cell update");
  a_start_to_wait: assert property (@(posedge clk) disable iff (rst)
    ctl.sqrt_start |=> (state == cwd_pkg::S_SQRT) && sqrt_busy)
    else $error("square root start not followed by wait");
  a_close_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    closing |=> !in_ready)
    else $error("closing item did not stop input");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |=> out_valid && (state == cwd_pkg::S_IDLE))
    else $error("result load did not present an item");
`endif

endmodule
